// ===== sv/tbie_pkg.sv =====
// package for the three-byte instruction execute block
// holds the word types, opcode constants, operation kinds and condition decode
// no dependencies
`timescale 1ns / 1ps

package tbie_pkg;

  // opcode bytes
  localparam logic [7:0] OPC_LXI_B  = 8'h01;
  localparam logic [7:0] OPC_LXI_D  = 8'h11;
  localparam logic [7:0] OPC_LXI_H  = 8'h21;
  localparam logic [7:0] OPC_SHLD   = 8'h22;
  localparam logic [7:0] OPC_LHLD   = 8'h2a;
  localparam logic [7:0] OPC_LXI_SP = 8'h31;
  localparam logic [7:0] OPC_STA    = 8'h32;
  localparam logic [7:0] OPC_LDA    = 8'h3a;
  localparam logic [7:0] OPC_JMP    = 8'hc3;
  localparam logic [7:0] OPC_CALL   = 8'hcd;
  localparam logic [7:0] OPC_JNZ    = 8'hc2;
  localparam logic [7:0] OPC_JZ     = 8'hca;
  localparam logic [7:0] OPC_JNC    = 8'hd2;
  localparam logic [7:0] OPC_JC     = 8'hda;
  localparam logic [7:0] OPC_JPO    = 8'he2;
  localparam logic [7:0] OPC_JPE    = 8'hea;
  localparam logic [7:0] OPC_JP     = 8'hf2;
  localparam logic [7:0] OPC_JM     = 8'hfa;
  localparam logic [7:0] OPC_CNZ    = 8'hc4;
  localparam logic [7:0] OPC_CZ     = 8'hcc;
  localparam logic [7:0] OPC_CNC    = 8'hd4;
  localparam logic [7:0] OPC_CC     = 8'hdc;
  localparam logic [7:0] OPC_CPO    = 8'he4;
  localparam logic [7:0] OPC_CPE    = 8'hec;
  localparam logic [7:0] OPC_CP     = 8'hf4;
  localparam logic [7:0] OPC_CM     = 8'hfc;

  // condition flag selects, opcode bits 5:4
  localparam logic [1:0] CSEL_ZERO   = 2'd0;
  localparam logic [1:0] CSEL_CARRY  = 2'd1;
  localparam logic [1:0] CSEL_PARITY = 2'd2;
  localparam logic [1:0] CSEL_SIGN   = 2'd3;

  // result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic [3:0] {
    OP_LXI_B,
    OP_LXI_D,
    OP_LXI_H,
    OP_LXI_SP,
    OP_SHLD,
    OP_LHLD,
    OP_STA,
    OP_LDA,
    OP_JUMP,
    OP_CALL,
    OP_BAD
  } op_kind_t;

  typedef enum logic [1:0] {
    EX_CLEAR,
    EX_ACCEPT,
    EX_FINISH
  } ex_state_t;

  typedef struct packed {
    logic [7:0] action;
    logic [7:0] low_byte;
    logic [7:0] high_byte;
    logic       zero_flag;
    logic       carry_flag;
    logic       parity_flag;
    logic       sign_flag;
  } cmd_word_t;

  typedef struct packed {
    logic        status;
    logic [15:0] next_pc;
    logic [15:0] new_sp;
    logic [7:0]  new_acc;
    logic [15:0] new_bc;
    logic [15:0] new_de;
    logic [15:0] new_hl;
  } res_word_t;

  // handshake between the core and the result register
  typedef struct packed {
    logic done;
  } core_status_t;

  typedef struct packed {
    logic free;
  } core_ctrl_t;

  function automatic op_kind_t decode_op(input logic [7:0] op);
    op_kind_t k;
    unique case (op)
      OPC_LXI_B:  k = OP_LXI_B;
      OPC_LXI_D:  k = OP_LXI_D;
      OPC_LXI_H:  k = OP_LXI_H;
      OPC_LXI_SP: k = OP_LXI_SP;
      OPC_SHLD:   k = OP_SHLD;
      OPC_LHLD:   k = OP_LHLD;
      OPC_STA:    k = OP_STA;
      OPC_LDA:    k = OP_LDA;
      OPC_JMP, OPC_JNZ, OPC_JZ, OPC_JNC, OPC_JC,
      OPC_JPO, OPC_JPE, OPC_JP, OPC_JM:
        k = OP_JUMP;
      OPC_CALL, OPC_CNZ, OPC_CZ, OPC_CNC, OPC_CC,
      OPC_CPO, OPC_CPE, OPC_CP, OPC_CM:
        k = OP_CALL;
      default:    k = OP_BAD;
    endcase
    return k;
  endfunction

  // condition code: bits 2:1 pick the flag, bit 0 set means flag must be one
  function automatic logic cond_met(input logic [2:0] cond, input logic z, input logic c,
                                    input logic p, input logic s);
    logic f;
    unique case (cond[2:1])
      CSEL_ZERO:   f = z;
      CSEL_CARRY:  f = c;
      CSEL_PARITY: f = p;
      CSEL_SIGN:   f = s;
      default:     f = s;
    endcase
    return cond[0] ? f : !f;
  endfunction

endpackage

// ===== sv/three_byte_instruction_execute.sv =====
// top level of the three-byte instruction execute block
// depends on tbie_pkg, tbie_mem and tbie_core
//
//   channel | direction | handshake           | word
//   cmd     | in        | cmd_valid/cmd_ready | tbie_pkg::cmd_word_t
//   res     | out       | res_valid/res_ready | tbie_pkg::res_word_t
//
// each word passes through an accept cycle and a finish cycle: memory accesses are
// issued in both, bounded by the single write port and the registered read ports.
// the result lands in an output register at the end of the finish cycle, so the
// next word is taken while a result waits.
// after reset the memory is cleared, with cmd_ready low.
// a full result register holds the core in its finish cycle until taken.
`timescale 1ns / 1ps

module three_byte_instruction_execute #(
  parameter int ADDR_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  tbie_pkg::cmd_word_t cmd,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  output tbie_pkg::res_word_t res,
  output logic                res_valid,
  input  logic                res_ready
);

  import tbie_pkg::*;

  core_ctrl_t           ctrl;
  core_status_t         stat;
  res_word_t            word;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [7:0]           wr_data;
  logic                 rd_en;
  logic [ADDR_BITS-1:0] rd_addr0;
  logic [ADDR_BITS-1:0] rd_addr1;
  logic [7:0]           rd_data0;
  logic [7:0]           rd_data1;

  assign ctrl.free = !res_valid || res_ready;

  tbie_core #(
    .ADDR_BITS(ADDR_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .ctrl     (ctrl),
    .stat     (stat),
    .word     (word),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  tbie_mem #(
    .ADDR_BITS(ADDR_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr0(rd_addr0),
    .rd_addr1(rd_addr1),
    .rd_data0(rd_data0),
    .rd_data1(rd_data1)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stat.done) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // output register word
  always_ff @(posedge clk) begin
    if (stat.done) begin
      res <= word;
    end
  end

endmodule

// ===== sv/tbie_mem.sv =====
// byte memory of the execute block: one write port, two registered read ports
// depends on nothing; depth follows the address width parameter
`timescale 1ns / 1ps

module tbie_mem #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [7:0]           wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr0,
  input  logic [ADDR_BITS-1:0] rd_addr1,
  output logic [7:0]           rd_data0,
  output logic [7:0]           rd_data1
);

  localparam int Depth = 1 << ADDR_BITS;

  logic [7:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

// ===== sv/tbie_core.sv =====
// execute sequencer of the three-byte instruction block: register file,
// decode, memory access sequencing and the clearing pass after reset
// depends on tbie_pkg
`timescale 1ns / 1ps

module tbie_core #(
  parameter int ADDR_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tbie_pkg::cmd_word_t    cmd,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  tbie_pkg::core_ctrl_t   ctrl,
  output tbie_pkg::core_status_t stat,
  output tbie_pkg::res_word_t    word,
  output logic                   wr_en,
  output logic [ADDR_BITS-1:0]   wr_addr,
  output logic [7:0]             wr_data,
  output logic                   rd_en,
  output logic [ADDR_BITS-1:0]   rd_addr0,
  output logic [ADDR_BITS-1:0]   rd_addr1,
  input  logic [7:0]             rd_data0,
  input  logic [7:0]             rd_data1
);

  import tbie_pkg::*;

  ex_state_t            state, state_next;
  logic [ADDR_BITS-1:0] clr_cnt, clr_cnt_next;

  logic [15:0] pc, sp, bc, de, hl;
  logic [7:0]  acc;
  logic [15:0] pc_next, sp_next, bc_next, de_next, hl_next;
  logic [7:0]  acc_next;

  // instruction held from the accept cycle to the finish cycle
  op_kind_t    kind;
  logic [15:0] imm;
  logic        taken;

  op_kind_t    in_kind;
  logic [15:0] in_imm;
  logic        in_taken;
  logic        accept;
  logic        finish;
  logic [15:0] ret_addr;
  logic [15:0] in_imm_p1;
  logic [15:0] imm_p1;
  logic [15:0] sp_m1;
  logic [15:0] sp_m2;

  // decode of the incoming word
  always_comb begin
    in_kind  = decode_op(cmd.action);
    in_imm   = {cmd.high_byte, cmd.low_byte};
    in_taken = (cmd.action == OPC_JMP) || (cmd.action == OPC_CALL) ||
               cond_met(cmd.action[5:3], cmd.zero_flag, cmd.carry_flag,
                        cmd.parity_flag, cmd.sign_flag);
  end

  assign ret_addr  = pc + 16'd3;
  assign in_imm_p1 = in_imm + 16'd1;
  assign imm_p1    = imm + 16'd1;
  assign sp_m1     = sp - 16'd1;
  assign sp_m2     = sp - 16'd2;

  // sequencer and memory port control
  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    cmd_ready    = 1'b0;
    accept       = 1'b0;
    finish       = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr0     = in_imm[ADDR_BITS-1:0];
    rd_addr1     = in_imm_p1[ADDR_BITS-1:0];
    unique case (state)
      EX_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_cnt;
        clr_cnt_next = clr_cnt + {{(ADDR_BITS-1){1'b0}}, 1'b1};
        if (&clr_cnt) begin
          state_next = EX_ACCEPT;
        end
      end
      EX_ACCEPT: begin
        cmd_ready = 1'b1;
        accept    = cmd_valid;
        if (accept) begin
          state_next = EX_FINISH;
          unique case (in_kind)
            OP_SHLD: begin
              wr_en   = 1'b1;
              wr_addr = in_imm[ADDR_BITS-1:0];
              wr_data = hl[7:0];
            end
            OP_STA: begin
              wr_en   = 1'b1;
              wr_addr = in_imm[ADDR_BITS-1:0];
              wr_data = acc;
            end
            OP_CALL: begin
              wr_en   = in_taken;
              wr_addr = sp_m1[ADDR_BITS-1:0];
              wr_data = ret_addr[15:8];
            end
            OP_LHLD, OP_LDA: begin
              rd_en = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      EX_FINISH: begin
        finish = ctrl.free;
        if (finish) begin
          state_next = EX_ACCEPT;
          unique case (kind)
            OP_SHLD: begin
              wr_en   = 1'b1;
              wr_addr = imm_p1[ADDR_BITS-1:0];
              wr_data = hl[15:8];
            end
            OP_CALL: begin
              wr_en   = taken;
              wr_addr = sp_m2[ADDR_BITS-1:0];
              wr_data = ret_addr[7:0];
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = EX_CLEAR;
      end
    endcase
  end

  // register file update, read data arrives in the finish cycle
  always_comb begin
    pc_next  = ret_addr;
    sp_next  = sp;
    acc_next = acc;
    bc_next  = bc;
    de_next  = de;
    hl_next  = hl;
    unique case (kind)
      OP_LXI_B:  bc_next  = imm;
      OP_LXI_D:  de_next  = imm;
      OP_LXI_H:  hl_next  = imm;
      OP_LXI_SP: sp_next  = imm;
      OP_LHLD:   hl_next  = {rd_data1, rd_data0};
      OP_LDA:    acc_next = rd_data0;
      OP_JUMP: begin
        if (taken) begin
          pc_next = imm;
        end
      end
      OP_CALL: begin
        if (taken) begin
          pc_next = imm;
          sp_next = sp_m2;
        end
      end
      OP_BAD:    pc_next  = pc;
      default:   pc_next  = ret_addr;
    endcase
  end

  // result word for the output register
  always_comb begin
    word.status  = (kind == OP_BAD) ? STATUS_BAD : STATUS_OK;
    word.next_pc = pc_next;
    word.new_sp  = sp_next;
    word.new_acc = acc_next;
    word.new_bc  = bc_next;
    word.new_de  = de_next;
    word.new_hl  = hl_next;
    stat.done    = finish;
  end

  // state, clear counter and register file
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= EX_CLEAR;
      clr_cnt <= '0;
      pc      <= '0;
      sp      <= '0;
      acc     <= '0;
      bc      <= '0;
      de      <= '0;
      hl      <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      if (finish) begin
        pc  <= pc_next;
        sp  <= sp_next;
        acc <= acc_next;
        bc  <= bc_next;
        de  <= de_next;
        hl  <= hl_next;
      end
    end
  end

  // held instruction fields
  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= in_kind;
      imm   <= in_imm;
      taken <= in_taken;
    end
  end

endmodule

// ===== test/tb_three_byte_instruction_execute.sv =====
// testbench for three_byte_instruction_execute: drives instruction words,
// predicts every register-file result word and checks it field by field
// depends on tbie_pkg and three_byte_instruction_execute
`timescale 1ns / 1ps

import tbie_pkg::*;

// shadow copy of the register file and byte memory, plus the results still owed
class cpu_shadow;
  logic [15:0] pc, sp, bc, de, hl;
  logic [7:0] acc;
  logic [7:0] mem [0:65535];
  int unsigned addr_mask;
  res_word_t state_q [$];
  int mismatches;

  function new(int addr_bits);
    pc = '0;
    sp = '0;
    bc = '0;
    de = '0;
    hl = '0;
    acc = '0;
    foreach (mem[i]) mem[i] = '0;
    addr_mask = (32'd1 << addr_bits) - 1;
    mismatches = 0;
  endfunction

  // memory index; wider addresses alias onto the low bits
  function int unsigned at(logic [15:0] a);
    return a & addr_mask;
  endfunction

  // execute one accepted instruction word and queue the register file it leaves
  function void take_instr(cmd_word_t w);
    logic [15:0] imm, ret, nxt;
    logic f, taken, st;
    res_word_t r;
    imm = {w.high_byte, w.low_byte};
    ret = pc + 16'd3;
    nxt = ret;
    st = STATUS_OK;

    // condition: opcode bits 5:4 pick the flag, bit 3 says which value takes it
    case (w.action[5:4])
      CSEL_ZERO:   f = w.zero_flag;
      CSEL_CARRY:  f = w.carry_flag;
      CSEL_PARITY: f = w.parity_flag;
      default:     f = w.sign_flag;
    endcase
    taken = w.action[3] ? f : !f;

    case (w.action)
      OPC_LXI_B:  bc = imm;
      OPC_LXI_D:  de = imm;
      OPC_LXI_H:  hl = imm;
      OPC_LXI_SP: sp = imm;
      OPC_SHLD: begin
        mem[at(imm)] = hl[7:0];
        mem[at(imm + 16'd1)] = hl[15:8];
      end
      OPC_LHLD: hl = {mem[at(imm + 16'd1)], mem[at(imm)]};
      OPC_STA:  mem[at(imm)] = acc;
      OPC_LDA:  acc = mem[at(imm)];
      OPC_JMP:  nxt = imm;
      OPC_JNZ, OPC_JZ, OPC_JNC, OPC_JC, OPC_JPO, OPC_JPE, OPC_JP, OPC_JM: begin
        if (taken) nxt = imm;
      end
      OPC_CALL, OPC_CNZ, OPC_CZ, OPC_CNC, OPC_CC, OPC_CPO, OPC_CPE, OPC_CP, OPC_CM: begin
        // return address goes high byte first, below the stack pointer
        if (w.action == OPC_CALL || taken) begin
          mem[at(sp - 16'd1)] = ret[15:8];
          mem[at(sp - 16'd2)] = ret[7:0];
          sp = sp - 16'd2;
          nxt = imm;
        end
      end
      default: begin
        st = STATUS_BAD;
        nxt = pc;
      end
    endcase
    pc = nxt;

    r.status = st;
    r.next_pc = pc;
    r.new_sp = sp;
    r.new_acc = acc;
    r.new_bc = bc;
    r.new_de = de;
    r.new_hl = hl;
    state_q.push_back(r);
  endfunction

  function void cmp(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", field, want, got);
      mismatches++;
    end
  endfunction

  // compare one result word against the oldest prediction
  function void check_state(res_word_t got);
    res_word_t want;
    if (state_q.size() == 0) begin
      $error("result word with no prediction pending");
      mismatches++;
      return;
    end
    want = state_q.pop_front();
    cmp("status", 16'(want.status), 16'(got.status));
    cmp("next_pc", want.next_pc, got.next_pc);
    cmp("new_sp", want.new_sp, got.new_sp);
    cmp("new_acc", 16'(want.new_acc), 16'(got.new_acc));
    cmp("new_bc", want.new_bc, got.new_bc);
    cmp("new_de", want.new_de, got.new_de);
    cmp("new_hl", want.new_hl, got.new_hl);
  endfunction
endclass

module tb_three_byte_instruction_execute;
  localparam int ADDR_BITS = 16;
  localparam int RANDOM_WORDS = 1850;

  // every supported opcode; conditional jumps start at 10, conditional calls at 18
  localparam logic [7:0] KNOWN_OPS [0:25] = '{
    OPC_LXI_B, OPC_LXI_D, OPC_LXI_H, OPC_LXI_SP, OPC_SHLD, OPC_LHLD, OPC_STA, OPC_LDA,
    OPC_JMP, OPC_CALL,
    OPC_JNZ, OPC_JZ, OPC_JNC, OPC_JC, OPC_JPO, OPC_JPE, OPC_JP, OPC_JM,
    OPC_CNZ, OPC_CZ, OPC_CNC, OPC_CC, OPC_CPO, OPC_CPE, OPC_CP, OPC_CM
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  cmd_word_t cmd = '0;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  res_word_t res;
  logic res_valid;
  logic res_ready = 1'b0;
  bit steady = 1'b0;
  cpu_shadow shadow;

  three_byte_instruction_execute #(
    .ADDR_BITS(ADDR_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .res(res),
    .res_valid(res_valid),
    .res_ready(res_ready)
  );

  always #5 clk = ~clk;

  // result side: random back-pressure and checking
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_ready) shadow.check_state(res);
    res_ready <= steady || ($urandom_range(0, 99) >= 31);
  end

  function automatic cmd_word_t make_instr(logic [7:0] op, logic [15:0] imm, logic [3:0] fl);
    cmd_word_t w;
    w.action = op;
    w.low_byte = imm[7:0];
    w.high_byte = imm[15:8];
    w.zero_flag = fl[3];
    w.carry_flag = fl[2];
    w.parity_flag = fl[1];
    w.sign_flag = fl[0];
    return w;
  endfunction

  // offer one instruction word, with a random gap before it
  task automatic send_cmd(input cmd_word_t w);
    if (!steady && $urandom_range(0, 99) < 31) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(0, 99) < 31);
    end
    cmd <= w;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_ready !== 1'b1);
    shadow.take_instr(w);
  endtask

  initial begin : stimulus
    int i;
    logic [7:0] op;
    logic [15:0] a;
    shadow = new(ADDR_BITS);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: loads, wrapping memory pairs, stack wrap below zero, pc wrap
    send_cmd(make_instr(OPC_LXI_B, 16'hFFFF, 4'h0));
    send_cmd(make_instr(OPC_LXI_D, 16'h0000, 4'hF));
    send_cmd(make_instr(OPC_LXI_H, 16'hA55A, 4'h0));
    send_cmd(make_instr(OPC_SHLD, 16'hFFFF, 4'hF));
    send_cmd(make_instr(OPC_LXI_H, 16'h0000, 4'h0));
    send_cmd(make_instr(OPC_LHLD, 16'hFFFF, 4'h0));
    send_cmd(make_instr(OPC_LDA, 16'h0000, 4'h0));
    send_cmd(make_instr(OPC_STA, 16'h8000, 4'h0));
    send_cmd(make_instr(OPC_LXI_SP, 16'h0000, 4'h0));
    send_cmd(make_instr(OPC_CALL, 16'hFFFF, 4'h0));
    send_cmd(make_instr(OPC_LXI_SP, 16'h0001, 4'h0));
    send_cmd(make_instr(OPC_JMP, 16'hFFFE, 4'h0));
    send_cmd(make_instr(8'h00, 16'h1234, 4'hF));
    send_cmd(make_instr(8'hFF, 16'hFFFF, 4'h0));

    // each conditional jump and call once, alternating taken and not taken
    for (i = 0; i < 8; i++) begin
      send_cmd(make_instr(KNOWN_OPS[10 + i], 16'h00F0 + 16'(i),
                          {4{KNOWN_OPS[10 + i][3] ^ i[0]}}));
      send_cmd(make_instr(KNOWN_OPS[18 + i], 16'hFF00 + 16'(i),
                          {4{KNOWN_OPS[18 + i][3] ^ ~i[0]}}));
    end

    // random: mostly supported opcodes on a few small address windows so that
    // loads read back what stores and calls left behind
    for (i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 600 && i < 900);
      if ($urandom_range(0, 9) == 0) op = 8'($urandom);
      else op = KNOWN_OPS[$urandom_range(0, 25)];
      case ($urandom_range(0, 3))
        0: a = 16'($urandom);
        1: a = {12'h000, 4'($urandom)};
        2: a = {12'hFFF, 4'($urandom)};
        default: a = {12'h800, 4'($urandom)};
      endcase
      send_cmd(make_instr(op, a, 4'($urandom)));
    end
    cmd_valid <= 1'b0;

    // drain
    while (shadow.state_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("tb_three_byte_instruction_execute: PASS");
    end else begin
      $display("tb_three_byte_instruction_execute: FAIL");
    end
    $finish;
  end

  // run limit, covers the memory clear after reset with a wide margin
  initial begin : watchdog
    #5000000;
    $display("tb_three_byte_instruction_execute: FAIL");
    $finish;
  end

endmodule
